[hw/rtl/ngdp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngdp_pkg
// Shared types and constants for the next greater digit permutation block.
// ----------------------------------------------------------------------------
package ngdp_pkg;

  localparam int DIGIT_W        = 4;
  localparam int VALUE_W        = 54;
  localparam int MAX_DIGITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } beat_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_SWAP,
    ST_REV_RD,
    ST_REV_WLO,
    ST_REV_WHI,
    ST_ACC_RD,
    ST_ACC_ADD,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

[hw/rtl/ngdp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngdp_front
// Accepts digit beats, clamps digits to nine and registers them for the queue.
// ----------------------------------------------------------------------------
module ngdp_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [ngdp_pkg::DIGIT_W-1:0]   digit_i,
  input  wire logic                           last_i,
  input  wire ngdp_pkg::q_stat_t              q_stat_i,
  output logic                                push_o,
  output ngdp_pkg::beat_t                     beat_o
);

  logic            valid_q, valid_d;
  logic            accept;
  ngdp_pkg::beat_t beat_q;

  assign in_stall_o = valid_q && q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !q_stat_i.full;
  assign beat_o     = beat_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      beat_q.digit <= (digit_i > ngdp_pkg::DIGIT_MAX) ? ngdp_pkg::DIGIT_MAX : digit_i;
      beat_q.last  <= last_i;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ngdp_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngdp_fifo
// Short beat queue between the front and the permutation engine.
// ----------------------------------------------------------------------------
module ngdp_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ngdp_pkg::beat_t   beat_i,
  input  wire logic              pop_i,
  output ngdp_pkg::beat_t        beat_o,
  output ngdp_pkg::q_stat_t      q_stat_o
);

  ngdp_pkg::beat_t                 entries_q [ngdp_pkg::QUEUE_DEPTH];
  logic [ngdp_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [ngdp_pkg::QCNT_W-1:0]     count_q, count_d;

  assign q_stat_o.full  = (count_q == ngdp_pkg::QCNT_W'(ngdp_pkg::QUEUE_DEPTH));
  assign q_stat_o.valid = (count_q != '0);
  assign beat_o         = entries_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= beat_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && q_stat_o.full))
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> q_stat_o.valid)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

[hw/rtl/ngdp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngdp_back
// Stores digits, finds the pivot, swaps, reverses the suffix and converts
// the digit string to binary.
// ----------------------------------------------------------------------------
module ngdp_back #(
  parameter int MAX_DIGITS = ngdp_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ngdp_pkg::q_stat_t             q_stat_i,
  input  wire ngdp_pkg::beat_t               beat_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ngdp_pkg::VALUE_W-1:0]       value_o,
  output logic                               found_o,
  output logic                               too_long_o
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int DW    = ngdp_pkg::DIGIT_W;
  localparam int VW    = ngdp_pkg::VALUE_W;

  ngdp_pkg::state_e state_q, state_d;

  logic [DW-1:0]    store_q [MAX_DIGITS];
  logic [DW-1:0]    rd_a_q, rd_b_q;
  logic             mem_we, rd_en;
  logic [IDX_W-1:0] wr_addr, ra_addr, rb_addr;
  logic [DW-1:0]    wr_data;

  logic [CNT_W-1:0] count_q, count_d, n_q, n_d, i_q, i_d;
  logic             ovf_q, ovf_d, found_q, found_d;
  logic [IDX_W-1:0] j_q, j_d, p_q, p_d, lo_q, lo_d, hi_q, hi_d;
  logic [DW-1:0]    piv_q, piv_d;
  logic [VW-1:0]    acc_q, acc_d;
  logic             out_free, out_load;

  logic [CNT_W-1:0] n_new, n_m1, count_inc, i_inc;
  logic             take, take_last;

  assign out_free  = !out_valid_o || !out_stall_i;
  assign take      = (state_q == ngdp_pkg::ST_LOAD) && q_stat_i.valid;
  assign take_last = take && beat_i.last;
  assign count_inc = count_q + 1'b1;
  assign n_new     = (count_q < CNT_W'(MAX_DIGITS)) ? count_inc : count_q;
  assign n_m1      = n_q - 1'b1;
  assign i_inc     = i_q + 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ngdp_pkg::ST_LOAD: begin
        if (take_last) begin
          state_d = (n_new < CNT_W'(2)) ? ngdp_pkg::ST_DONE : ngdp_pkg::ST_SCAN_RD;
        end
      end
      ngdp_pkg::ST_SCAN_RD:  state_d = ngdp_pkg::ST_SCAN_CHK;
      ngdp_pkg::ST_SCAN_CHK: begin
        priority if (rd_a_q < rd_b_q) begin
          state_d = ngdp_pkg::ST_FIND_RD;
        end else if (j_q == IDX_W'(1)) begin
          state_d = ngdp_pkg::ST_DONE;
        end else begin
          state_d = ngdp_pkg::ST_SCAN_RD;
        end
      end
      ngdp_pkg::ST_FIND_RD:  state_d = ngdp_pkg::ST_FIND_CHK;
      ngdp_pkg::ST_FIND_CHK: begin
        state_d = (rd_b_q > piv_q) ? ngdp_pkg::ST_SWAP : ngdp_pkg::ST_FIND_RD;
      end
      ngdp_pkg::ST_SWAP:     state_d = ngdp_pkg::ST_REV_RD;
      ngdp_pkg::ST_REV_RD: begin
        state_d = (lo_q < hi_q) ? ngdp_pkg::ST_REV_WLO : ngdp_pkg::ST_ACC_RD;
      end
      ngdp_pkg::ST_REV_WLO:  state_d = ngdp_pkg::ST_REV_WHI;
      ngdp_pkg::ST_REV_WHI:  state_d = ngdp_pkg::ST_REV_RD;
      ngdp_pkg::ST_ACC_RD:   state_d = ngdp_pkg::ST_ACC_ADD;
      ngdp_pkg::ST_ACC_ADD: begin
        state_d = (i_inc == n_q) ? ngdp_pkg::ST_DONE : ngdp_pkg::ST_ACC_RD;
      end
      ngdp_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = ngdp_pkg::ST_LOAD;
        end
      end
      default: state_d = ngdp_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    count_d  = count_q;
    ovf_d    = ovf_q;
    n_d      = n_q;
    i_d      = i_q;
    j_d      = j_q;
    p_d      = p_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    piv_d    = piv_q;
    acc_d    = acc_q;
    found_d  = found_q;
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = '0;
    ra_addr  = '0;
    rb_addr  = '0;
    pop_o    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ngdp_pkg::ST_LOAD: begin
        pop_o = take;
        if (take) begin
          if (count_q < CNT_W'(MAX_DIGITS)) begin
            mem_we  = 1'b1;
            wr_addr = count_q[IDX_W-1:0];
            wr_data = beat_i.digit;
            count_d = count_inc;
          end else begin
            ovf_d = 1'b1;
          end
          if (beat_i.last) begin
            n_d     = n_new;
            j_d     = IDX_W'(n_new - 1'b1);
            found_d = 1'b0;
          end
        end
      end
      ngdp_pkg::ST_SCAN_RD: begin
        rd_en   = 1'b1;
        ra_addr = j_q - 1'b1;
        rb_addr = j_q;
      end
      ngdp_pkg::ST_SCAN_CHK: begin
        if (rd_a_q < rd_b_q) begin
          p_d     = j_q - 1'b1;
          piv_d   = rd_a_q;
          j_d     = n_m1[IDX_W-1:0];
          found_d = 1'b1;
        end else begin
          j_d = j_q - 1'b1;
        end
      end
      ngdp_pkg::ST_FIND_RD: begin
        rd_en   = 1'b1;
        ra_addr = j_q;
        rb_addr = j_q;
      end
      ngdp_pkg::ST_FIND_CHK: begin
        if (rd_b_q > piv_q) begin
          mem_we  = 1'b1;
          wr_addr = p_q;
          wr_data = rd_b_q;
        end else begin
          j_d = j_q - 1'b1;
        end
      end
      ngdp_pkg::ST_SWAP: begin
        mem_we  = 1'b1;
        wr_addr = j_q;
        wr_data = piv_q;
        lo_d    = p_q + 1'b1;
        hi_d    = n_m1[IDX_W-1:0];
      end
      ngdp_pkg::ST_REV_RD: begin
        rd_en   = 1'b1;
        ra_addr = lo_q;
        rb_addr = hi_q;
        if (!(lo_q < hi_q)) begin
          acc_d = '0;
          i_d   = '0;
        end
      end
      ngdp_pkg::ST_REV_WLO: begin
        mem_we  = 1'b1;
        wr_addr = lo_q;
        wr_data = rd_b_q;
      end
      ngdp_pkg::ST_REV_WHI: begin
        mem_we  = 1'b1;
        wr_addr = hi_q;
        wr_data = rd_a_q;
        lo_d    = lo_q + 1'b1;
        hi_d    = hi_q - 1'b1;
      end
      ngdp_pkg::ST_ACC_RD: begin
        rd_en   = 1'b1;
        ra_addr = i_q[IDX_W-1:0];
        rb_addr = i_q[IDX_W-1:0];
      end
      ngdp_pkg::ST_ACC_ADD: begin
        // acc * 10 + digit, wrapping at the value width
        acc_d = (acc_q << 3) + (acc_q << 1) + {{(VW-DW){1'b0}}, rd_a_q};
        i_d   = i_inc;
      end
      ngdp_pkg::ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          count_d  = '0;
          ovf_d    = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ngdp_pkg::ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    i_q     <= i_d;
    j_q     <= j_d;
    p_q     <= p_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    piv_q   <= piv_d;
    acc_q   <= acc_d;
    found_q <= found_d;
    if (out_load) begin
      value_o    <= found_q ? acc_q : '0;
      found_o    <= found_q;
      too_long_o <= ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= store_q[ra_addr];
      rd_b_q <= store_q[rb_addr];
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  a_find_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ngdp_pkg::ST_FIND_CHK) |-> (j_q > p_q))
    else $error("successor search passed the pivot");

  a_rev_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ngdp_pkg::ST_REV_WLO) |-> (lo_q < hi_q))
    else $error("reverse swap with crossed pointers");

  a_nofound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (value_o == '0))
    else $error("nonzero value without a pivot");

endmodule
`default_nettype wire

[hw/rtl/next_greater_digit_permutation.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// next_greater_digit_permutation
// Next greater number from the same decimal digits, fed one digit per beat.
//
//   channel  dir  handshake                payload
//   in       in   in_valid_i / in_stall_o  digit_i, last_i
//   out      out  out_valid_o/out_stall_i  value_o, found_o, too_long_o
//
// Digit beats enter one per cycle while the queue is not full, through a
// register and a four-beat queue. After the last digit of an n-digit number
// the engine runs a pivot scan, a successor search, a suffix reverse and a
// binary conversion, reading from the two-read-port digit store.
// No clearing pass after reset. The result register holds while out_stall_i
// is high; input beats keep queueing until the queue fills.
// ----------------------------------------------------------------------------
module next_greater_digit_permutation #(
  parameter int MAX_DIGITS = ngdp_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [ngdp_pkg::DIGIT_W-1:0]  digit_i,
  input  wire logic                          last_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ngdp_pkg::VALUE_W-1:0]       value_o,
  output logic                               found_o,
  output logic                               too_long_o
);

  ngdp_pkg::q_stat_t q_stat;
  ngdp_pkg::beat_t   push_beat, pop_beat;
  logic              push, pop;

  ngdp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .digit_i    (digit_i),
    .last_i     (last_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .beat_o     (push_beat)
  );

  ngdp_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .beat_i   (push_beat),
    .pop_i    (pop),
    .beat_o   (pop_beat),
    .q_stat_o (q_stat)
  );

  ngdp_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .beat_i      (pop_beat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .found_o     (found_o),
    .too_long_o  (too_long_o)
  );

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for next_greater_digit_permutation. Digit beats go in
// with random gaps while the result side stalls at random. Every beat is fed
// to a local next-permutation predictor, and every result beat is checked
// field by field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module testbench;
  import ngdp_pkg::*;

  localparam int     NDIG         = MAX_DIGITS_DEF;
  localparam int     RX_HOLD      = 300;
  localparam int     DRAIN_CYCLES = 200;
  localparam int     RANDOM_BEATS = 520;
  localparam longint LIMIT_NS     = 2000000;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               found;
    logic               too_long;
  } perm_t;

  typedef struct {
    int          len;
    logic [79:0] digs;
    bit          pin;
    perm_t       res;
  } dir_row_t;

  typedef enum int {NUM_PLAIN, NUM_FEW, NUM_FALLING, NUM_NOISY} num_style_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [DIGIT_W-1:0] digit_i;
  logic               last_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [VALUE_W-1:0] value_o;
  logic               found_o;
  logic               too_long_o;

  logic [DIGIT_W-1:0] held_digits [NDIG];
  int                 held_count;
  logic               held_overflow;
  perm_t              pending_perms [$];
  perm_t              pinned_perm;
  bit                 pin_armed;
  int                 errors;
  int                 beats_sent;
  bit                 no_idle;
  bit                 tx_burst;
  bit                 hold_req;

  next_greater_digit_permutation #(
    .MAX_DIGITS(NDIG)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .digit_i    (digit_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_o    (value_o),
    .found_o    (found_o),
    .too_long_o (too_long_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int gap_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  task automatic flag_error(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  // Stores one digit; on the final digit forms the next permutation in place.
  function automatic void absorb_digit(input logic [DIGIT_W-1:0] d, input logic fin);
    logic [DIGIT_W-1:0] t;
    logic [63:0]        acc;
    int                 p, j, lo, hi;
    perm_t              r;
    if (held_count < NDIG) begin
      held_digits[held_count] = (d > DIGIT_MAX) ? DIGIT_MAX : d;
      held_count++;
    end else begin
      held_overflow = 1'b1;
    end
    if (fin) begin
      p = -1;
      for (j = held_count - 1; j > 0 && p < 0; j--)
        if (held_digits[j-1] < held_digits[j]) p = j - 1;
      acc = '0;
      if (p >= 0) begin
        j = held_count - 1;
        while (held_digits[j] <= held_digits[p]) j--;
        t = held_digits[p];
        held_digits[p] = held_digits[j];
        held_digits[j] = t;
        lo = p + 1;
        hi = held_count - 1;
        while (lo < hi) begin
          t = held_digits[lo];
          held_digits[lo] = held_digits[hi];
          held_digits[hi] = t;
          lo++;
          hi--;
        end
        for (j = 0; j < held_count; j++) acc = acc * 10 + held_digits[j];
      end
      r.value    = acc[VALUE_W-1:0];
      r.found    = (p >= 0);
      r.too_long = held_overflow;
      pending_perms.push_back(pin_armed ? pinned_perm : r);
      pin_armed     = 1'b0;
      held_count    = 0;
      held_overflow = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) absorb_digit(digit_i, last_i);
  end

  always @(posedge clk_i) begin : result_check
    perm_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_perms.size() == 0) begin
        flag_error($sformatf("result beat with nothing pending, value %0d", value_o));
      end else begin
        want = pending_perms.pop_front();
        if (value_o !== want.value)
          flag_error($sformatf("value got %0d want %0d", value_o, want.value));
        if (found_o !== want.found)
          flag_error($sformatf("found got %0b want %0b", found_o, want.found));
        if (too_long_o !== want.too_long)
          flag_error($sformatf("too_long got %0b want %0b", too_long_o, want.too_long));
      end
    end
  end

  initial begin : rx_side
    int stall_left;
    int hold_left;
    out_stall_i = 1'b0;
    stall_left  = 0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = RX_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (no_idle) begin
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [DIGIT_W-1:0] d, input logic fin);
    if (!no_idle && !tx_burst && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_len()) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    digit_i    <= d;
    last_i     <= fin;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_number(input int len, input num_style_e style);
    logic [DIGIT_W-1:0] ds [$];
    int                 i;
    for (i = 0; i < len; i++) begin
      case (style)
        NUM_FEW:   ds.push_back(DIGIT_W'($urandom_range(0, 2)));
        NUM_NOISY: ds.push_back(DIGIT_W'($urandom_range(0, 15)));
        default:   ds.push_back(DIGIT_W'($urandom_range(0, 9)));
      endcase
    end
    if (style == NUM_FALLING) ds.rsort();
    for (i = 0; i < len; i++) send_beat(ds[i], i == len - 1);
  endtask

  task automatic random_number();
    int         sel;
    int         len;
    num_style_e style;
    sel = $urandom_range(0, 19);
    if (sel == 0) len = 1;
    else if (sel == 1) len = $urandom_range(NDIG + 1, NDIG + 4);
    else len = $urandom_range(2, NDIG);
    sel = $urandom_range(0, 9);
    if (sel < 6) style = NUM_PLAIN;
    else if (sel < 8) style = NUM_FEW;
    else if (sel == 8) style = NUM_FALLING;
    else style = NUM_NOISY;
    send_number(len, style);
  endtask

  initial begin : main_seq
    dir_row_t rows [6];
    int       r, i;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    digit_i       = '0;
    last_i        = 1'b0;
    errors        = 0;
    beats_sent    = 0;
    no_idle       = 1'b0;
    tx_burst      = 1'b0;
    hold_req      = 1'b0;
    pin_armed     = 1'b0;
    held_count    = 0;
    held_overflow = 1'b0;
    rows = '{
      '{1,  80'h5,                 1'b1, '{54'd0,  1'b0, 1'b0}},
      '{2,  80'h12,                1'b1, '{54'd21, 1'b1, 1'b0}},
      '{2,  80'h21,                1'b1, '{54'd0,  1'b0, 1'b0}},
      '{2,  80'h1F,                1'b1, '{54'd91, 1'b1, 1'b0}},
      '{4,  80'h1243,              1'b0, '{54'd0,  1'b0, 1'b0}},
      '{17, 80'h99999999999999999, 1'b1, '{54'd0,  1'b0, 1'b1}}
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (r = 0; r < 6; r++) begin
      pinned_perm = rows[r].res;
      pin_armed   = rows[r].pin;
      for (i = 0; i < rows[r].len; i++)
        send_beat(rows[r].digs[4*(rows[r].len-1-i) +: 4], i == rows[r].len - 1);
    end

    while (beats_sent < 200) random_number();

    // long result-side hold while short numbers keep coming
    hold_req = 1'b1;
    tx_burst = 1'b1;
    for (i = 0; i < 30; i++) send_number($urandom_range(1, 3), NUM_PLAIN);
    tx_burst = 1'b0;

    in_valid_i <= 1'b0;
    wait (pending_perms.size() == 0);
    @(negedge clk_i);

    no_idle = 1'b1;
    while (beats_sent < 320) random_number();
    no_idle = 1'b0;

    while (beats_sent < 28 + RANDOM_BEATS) random_number();

    in_valid_i <= 1'b0;
    wait (pending_perms.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
